[rtl/core/tkvs_pkg.sv]
// Package for the top-K vector similarity search block.
// Holds sizes, codes, the hit-list entry and cell control types, and the rank compare.
// No dependencies.
package tkvs_pkg;

   localparam int MAX_DIM    = 256;
   localparam int MAX_KEEP   = 16;
   localparam int DIM_IDX_W  = $clog2(MAX_DIM);
   localparam int QCNT_W     = $clog2(MAX_DIM + 2);
   localparam int FILL_W     = $clog2(MAX_KEEP + 1);

   localparam int KIND_W     = 2;
   localparam int ID_W       = 32;
   localparam int VALUE_W    = 16;
   localparam int RANK_W     = 4;
   localparam int SCORE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int LEN_W      = 9;
   localparam int KEEP_W     = 5;

   localparam int ACC_W      = 48;
   localparam int ROOT_W     = ACC_W / 2;
   localparam int DVD_W      = 64;
   localparam int DIV_CNT_W  = $clog2(DVD_W);
   localparam int COS_SHIFT  = 15;
   localparam int COS_MAG_W  = COS_SHIFT + 2;
   localparam int COS_ONE    = 32768;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam logic [LEN_W-1:0]  VECTOR_LENGTH_RESET = LEN_W'(MAX_DIM);
   localparam logic [KEEP_W-1:0] KEEP_COUNT_RESET    = KEEP_W'(MAX_KEEP);
   localparam logic              METRIC_COSINE       = 1'b0;
   localparam logic              METRIC_EUCLID       = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_QUERY  = 2'd0,
      KIND_RECORD = 2'd1,
      KIND_END    = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_HIT      = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_MISMATCH = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_VECTOR_LENGTH = 2'd0,
      REG_KEEP_COUNT    = 2'd1,
      REG_METRIC_MODE   = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic                      valid;
      logic signed [SCORE_W-1:0] score;
      logic [ID_W-1:0]           id;
   } entry_type;

   typedef struct packed {
      logic                      insert;
      logic                      shift;
      logic                      clear;
      logic                      mode;
      logic signed [SCORE_W-1:0] score;
      logic [ID_W-1:0]           id;
   } cell_ctl_type;

   function automatic logic better(input logic mode, input logic signed [SCORE_W-1:0] a,
                                   input logic signed [SCORE_W-1:0] b);
      logic result;
      if (mode == METRIC_COSINE) begin
         result = a > b;
      end else begin
         result = a < b;
      end
      return result;
   endfunction

endpackage

[rtl/core/tkvs_intf.sv]
// Request and response channel interfaces of the top-K similarity search.
// Depends on tkvs_pkg for field widths.
interface tkvs_req_if;
   import tkvs_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic [ID_W-1:0]           record_id;
   logic signed [VALUE_W-1:0] value;
   modport source (output valid, kind, record_id, value, input ready);
   modport sink (input valid, kind, record_id, value, output ready);
endinterface

interface tkvs_rsp_if;
   import tkvs_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [RANK_W-1:0]         rank;
   logic [ID_W-1:0]           hit_id;
   logic signed [SCORE_W-1:0] score;
   logic [STATUS_W-1:0]       status;
   logic                      last;
   modport source (output valid, rank, hit_id, score, status, last, input ready);
   modport sink (input valid, rank, hit_id, score, status, last, output ready);
endinterface

[rtl/core/tkvs_cell.sv]
// One cell of the sorted hit list: holds one entry and trades it with its neighbors.
// Depends on tkvs_pkg.
module tkvs_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  tkvs_pkg::cell_ctl_type ctl,
   input  tkvs_pkg::entry_type    left_entry,
   input  logic                   left_take,
   input  tkvs_pkg::entry_type    right_entry,
   input  logic                   right_take,
   output tkvs_pkg::entry_type    entry,
   output logic                   take
);
   import tkvs_pkg::*;

   logic                      valid_ff, valid_in;
   logic signed [SCORE_W-1:0] score_ff, score_in;
   logic [ID_W-1:0]           id_ff, id_in;

   // A new score passes this cell if it beats it and every cell behind it.
   assign take = (!valid_ff || better(ctl.mode, ctl.score, score_ff)) && right_take;
   assign entry = '{valid: valid_ff, score: score_ff, id: id_ff};

   always_comb begin
      valid_in = valid_ff;
      score_in = score_ff;
      id_in    = id_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.insert) begin
         if (left_take) begin
            valid_in = left_entry.valid;
            score_in = left_entry.score;
            id_in    = left_entry.id;
         end else if (take) begin
            valid_in = 1'b1;
            score_in = ctl.score;
            id_in    = ctl.id;
         end
      end else if (ctl.shift) begin
         valid_in = right_entry.valid;
         score_in = right_entry.score;
         id_in    = right_entry.id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      score_ff <= score_in;
      id_ff    <= id_in;
   end

endmodule

[rtl/core/tkvs_sqrt.sv]
// Integer square root unit, two radicand bits per cycle.
// Depends on tkvs_pkg.
module tkvs_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tkvs_pkg::ACC_W-1:0]  operand,
   output logic                        done,
   output logic [tkvs_pkg::ROOT_W-1:0] root
);
   import tkvs_pkg::*;

   logic             busy_ff, done_ff;
   logic [ACC_W-1:0] rem_ff, root_ff, bit_ff, trial;

   assign trial = root_ff + bit_ff;
   assign done  = done_ff;
   assign root  = root_ff[ROOT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && bit_ff[0];
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && bit_ff[0]) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= operand;
         root_ff <= '0;
         bit_ff  <= ACC_W'(1) << (ACC_W - 2);
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_ff  <= rem_ff - trial;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

endmodule

[rtl/core/tkvs_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on tkvs_pkg.
module tkvs_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tkvs_pkg::DVD_W-1:0] dividend,
   input  logic [tkvs_pkg::ACC_W-1:0] divisor,
   output logic                       done,
   output logic [tkvs_pkg::DVD_W-1:0] quotient
);
   import tkvs_pkg::*;

   logic                 busy_ff, done_ff, last_step, fits;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DVD_W-1:0]     quo_ff;
   logic [ACC_W:0]       rem_ff, rem_sh;
   logic [ACC_W-1:0]     dvs_ff;

   assign rem_sh    = {rem_ff[ACC_W-1:0], quo_ff[DVD_W-1]};
   assign fits      = rem_sh >= {1'b0, dvs_ff};
   assign last_step = cnt_ff == DIV_CNT_W'(DVD_W - 1);
   assign done      = done_ff;
   assign quotient  = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && last_step;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last_step) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? rem_sh - {1'b0, dvs_ff} : rem_sh;
         quo_ff <= {quo_ff[DVD_W-2:0], fits};
      end
   end

endmodule

[rtl/core/top_k_vector_similarity_search.sv]
// Top level of the top-K vector similarity search: query store, accumulators, scoring
// sequencer and the chain of hit-list cells. Depends on tkvs_pkg, tkvs_intf, tkvs_cell,
// tkvs_sqrt and tkvs_div.
//
//   Channel   Role      Handshake          Carries
//   req_if    sink      valid/ready        kind, record_id, value
//   rsp_if    source    valid/ready        rank, hit_id, score, status, last
//   csr_*     slave     APB write/read     vector_length, keep_count, metric_mode
//
// Query elements and unused kinds are handled in the idle state; a record element
// also passes through the accumulate state. The element that completes a record is then
// scored with the shared square root unit and, for cosine, the bit-serial divider.
// An end request emits its responses after the end state, holding while rsp_if stalls.
// Reset is synchronous; the query store needs no clearing pass after it.
module top_k_vector_similarity_search (
   input  logic                            clock,
   input  logic                            reset,
   tkvs_req_if.sink                        req_if,
   tkvs_rsp_if.source                      rsp_if,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tkvs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tkvs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tkvs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import tkvs_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_MAC    = 10'b0000000010,
      S_SCORE  = 10'b0000000100,
      S_SQ_A   = 10'b0000001000,
      S_SQ_B   = 10'b0000010000,
      S_MUL    = 10'b0000100000,
      S_DIV    = 10'b0001000000,
      S_INSERT = 10'b0010000000,
      S_END    = 10'b0100000000,
      S_EMIT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [LEN_W-1:0]  vector_length_ff;
   logic [KEEP_W-1:0] keep_count_ff;
   logic              metric_mode_ff;

   logic signed [VALUE_W-1:0] qmem [MAX_DIM];
   logic signed [VALUE_W-1:0] q_rd_ff;

   logic [QCNT_W-1:0]         qfill_ff, elem_ff, elem_next;
   logic [ACC_W-1:0]          qnorm_ff, rnorm_ff, dsq_ff;
   logic signed [ACC_W-1:0]   dot_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [ID_W-1:0]           id_ff;
   logic [FILL_W-1:0]         best_fill_ff, k_ff;
   logic                      seen_ff;
   logic [ROOT_W-1:0]         root_a_ff;
   logic signed [SCORE_W-1:0] score_ff;
   logic [RANK_W-1:0]         rank_ff;

   logic                      rsp_valid_ff, rsp_last_ff;
   logic [RANK_W-1:0]         rsp_rank_ff;
   logic [ID_W-1:0]           rsp_hit_id_ff;
   logic signed [SCORE_W-1:0] rsp_score_ff;
   status_type                rsp_status_ff;

   logic req_fire, csr_write, query_fire, query_store_en, rec_done, slot_free;
   logic mismatch, empty, neg;
   logic [LEN_W-1:0]  len_eff;
   logic [FILL_W-1:0] keep_eff, k_calc;

   logic signed [VALUE_W-1:0]     q_use;
   logic signed [2*VALUE_W-1:0]   in_sq, prod_dot, prod_rn;
   logic signed [VALUE_W:0]       diff;
   logic signed [2*VALUE_W+1:0]   prod_dsq;
   logic [ACC_W-1:0]              dot_mag;
   logic [2*ROOT_W-1:0]           den;
   logic [COS_MAG_W-1:0]          cos_mag;
   logic signed [SCORE_W-1:0]     cos_score;

   logic              sq_start, sq_done, div_start, div_done;
   logic [ACC_W-1:0]  sq_operand;
   logic [ROOT_W-1:0] sq_root;
   logic [DVD_W-1:0]  div_quot;

   logic root_a_load, score_load, k_load, do_clear, do_mac, do_insert;
   logic rsp_load, rsp_load_last;
   logic signed [SCORE_W-1:0] score_val;
   logic [RANK_W-1:0]         rsp_rank_val;
   logic [ID_W-1:0]           rsp_id_val;
   logic signed [SCORE_W-1:0] rsp_score_val;
   status_type                rsp_status_val;

   cell_ctl_type        ctl;
   entry_type           entries [MAX_KEEP];
   logic                takes   [MAX_KEEP];
   logic [MAX_KEEP-1:0] valid_vec;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]))
         REG_VECTOR_LENGTH: csr_prdata = CSR_DATA_W'(vector_length_ff);
         REG_KEEP_COUNT:    csr_prdata = CSR_DATA_W'(keep_count_ff);
         REG_METRIC_MODE:   csr_prdata = CSR_DATA_W'(metric_mode_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vector_length_ff <= VECTOR_LENGTH_RESET;
         keep_count_ff    <= KEEP_COUNT_RESET;
         metric_mode_ff   <= METRIC_COSINE;
      end else if (csr_write) begin
         case (reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]))
            REG_VECTOR_LENGTH: vector_length_ff <= csr_pwdata[LEN_W-1:0];
            REG_KEEP_COUNT:    keep_count_ff    <= csr_pwdata[KEEP_W-1:0];
            REG_METRIC_MODE:   metric_mode_ff   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Request side and element arithmetic.
   assign req_if.ready   = state_ff == S_IDLE;
   assign req_fire       = req_if.valid && req_if.ready;
   assign query_fire     = req_fire && kind_type'(req_if.kind) == KIND_QUERY;
   assign query_store_en = query_fire && qfill_ff < QCNT_W'(MAX_DIM);

   always_comb begin
      if (vector_length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (vector_length_ff > LEN_W'(MAX_DIM)) begin
         len_eff = LEN_W'(MAX_DIM);
      end else begin
         len_eff = vector_length_ff;
      end
   end

   assign keep_eff = (keep_count_ff > KEEP_W'(MAX_KEEP)) ? FILL_W'(MAX_KEEP)
                                                         : FILL_W'(keep_count_ff);
   assign k_calc   = (keep_eff > best_fill_ff) ? best_fill_ff : keep_eff;
   assign mismatch = qfill_ff != QCNT_W'(len_eff);
   assign empty    = !seen_ff || keep_eff == '0;

   assign in_sq     = req_if.value * req_if.value;
   assign q_use     = (elem_ff < qfill_ff && elem_ff < QCNT_W'(MAX_DIM)) ? q_rd_ff : '0;
   assign prod_dot  = q_use * value_ff;
   assign prod_rn   = value_ff * value_ff;
   assign diff      = $signed({q_use[VALUE_W-1], q_use})
                    - $signed({value_ff[VALUE_W-1], value_ff});
   assign prod_dsq  = diff * diff;
   assign elem_next = elem_ff + 1'b1;
   assign rec_done  = elem_next >= QCNT_W'(len_eff);

   always_ff @(posedge clock) begin
      if (query_store_en) begin
         qmem[qfill_ff[DIM_IDX_W-1:0]] <= req_if.value;
      end
      q_rd_ff <= qmem[elem_ff[DIM_IDX_W-1:0]];
   end

   // Cosine arithmetic.
   assign neg     = dot_ff[ACC_W-1];
   assign dot_mag = neg ? ACC_W'(-dot_ff) : ACC_W'(dot_ff);
   assign den     = root_a_ff * sq_root;
   assign cos_mag = (|div_quot[DVD_W-1:COS_MAG_W] || div_quot[COS_MAG_W-1:0] >
                     COS_MAG_W'(COS_ONE)) ? COS_MAG_W'(COS_ONE) : div_quot[COS_MAG_W-1:0];
   assign cos_score = neg ? -$signed(SCORE_W'(cos_mag)) : $signed(SCORE_W'(cos_mag));

   tkvs_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (sq_operand),
      .done    (sq_done),
      .root    (sq_root)
   );

   tkvs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({1'b0, dot_mag, COS_SHIFT'(0)}),
      .divisor  (ACC_W'(den)),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in       = state_ff;
      sq_start       = 1'b0;
      sq_operand     = qnorm_ff;
      div_start      = 1'b0;
      root_a_load    = 1'b0;
      score_load     = 1'b0;
      score_val      = cos_score;
      k_load         = 1'b0;
      do_clear       = 1'b0;
      do_mac         = 1'b0;
      do_insert      = 1'b0;
      rsp_load       = 1'b0;
      rsp_load_last  = 1'b1;
      rsp_rank_val   = '0;
      rsp_id_val     = '0;
      rsp_score_val  = '0;
      rsp_status_val = STATUS_HIT;
      ctl            = '{insert: 1'b0, shift: 1'b0, clear: 1'b0, mode: metric_mode_ff,
                         score: score_ff, id: id_ff};
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (kind_type'(req_if.kind))
                  KIND_RECORD: state_in = S_MAC;
                  KIND_END:    state_in = S_END;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_MAC: begin
            do_mac   = 1'b1;
            state_in = rec_done ? S_SCORE : S_IDLE;
         end
         S_SCORE: begin
            if (metric_mode_ff == METRIC_EUCLID) begin
               sq_start   = 1'b1;
               sq_operand = dsq_ff;
               state_in   = S_SQ_A;
            end else if (qnorm_ff == '0 || rnorm_ff == '0) begin
               score_load = 1'b1;
               score_val  = '0;
               state_in   = S_INSERT;
            end else begin
               sq_start = 1'b1;
               state_in = S_SQ_A;
            end
         end
         S_SQ_A: begin
            if (sq_done) begin
               if (metric_mode_ff == METRIC_EUCLID) begin
                  score_load = 1'b1;
                  score_val  = SCORE_W'(sq_root);
                  state_in   = S_INSERT;
               end else begin
                  root_a_load = 1'b1;
                  sq_start    = 1'b1;
                  sq_operand  = rnorm_ff;
                  state_in    = S_SQ_B;
               end
            end
         end
         S_SQ_B: begin
            if (sq_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               score_load = 1'b1;
               state_in   = S_INSERT;
            end
         end
         S_INSERT: begin
            ctl.insert = 1'b1;
            do_insert  = 1'b1;
            state_in   = S_IDLE;
         end
         S_END: begin
            if (mismatch || empty) begin
               if (slot_free) begin
                  rsp_load       = 1'b1;
                  rsp_status_val = mismatch ? STATUS_MISMATCH : STATUS_EMPTY;
                  do_clear       = 1'b1;
                  ctl.clear      = 1'b1;
                  state_in       = S_IDLE;
               end
            end else begin
               k_load   = 1'b1;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_load      = 1'b1;
               rsp_rank_val  = rank_ff;
               rsp_id_val    = entries[0].id;
               rsp_score_val = entries[0].score;
               rsp_load_last = FILL_W'(rank_ff) + 1'b1 == k_ff;
               ctl.shift     = 1'b1;
               if (rsp_load_last) begin
                  do_clear  = 1'b1;
                  ctl.clear = 1'b1;
                  state_in  = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         qfill_ff     <= '0;
         qnorm_ff     <= '0;
         elem_ff      <= '0;
         dot_ff       <= '0;
         rnorm_ff     <= '0;
         dsq_ff       <= '0;
         best_fill_ff <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (do_clear) begin
            qfill_ff <= '0;
            qnorm_ff <= '0;
         end else if (query_fire) begin
            if (qfill_ff < QCNT_W'(MAX_DIM + 1)) begin
               qfill_ff <= qfill_ff + 1'b1;
            end
            if (query_store_en) begin
               qnorm_ff <= qnorm_ff + ACC_W'($unsigned(in_sq));
            end
         end
         if (do_clear || do_insert) begin
            elem_ff  <= '0;
            dot_ff   <= '0;
            rnorm_ff <= '0;
            dsq_ff   <= '0;
         end else if (do_mac) begin
            elem_ff  <= elem_next;
            dot_ff   <= dot_ff + ACC_W'(prod_dot);
            rnorm_ff <= rnorm_ff + ACC_W'($unsigned(prod_rn));
            dsq_ff   <= dsq_ff + ACC_W'($unsigned(prod_dsq));
         end
         if (do_clear) begin
            best_fill_ff <= '0;
            seen_ff      <= 1'b0;
         end else if (do_insert) begin
            seen_ff <= 1'b1;
            if (best_fill_ff < FILL_W'(MAX_KEEP)) begin
               best_fill_ff <= best_fill_ff + 1'b1;
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         value_ff <= req_if.value;
         id_ff    <= req_if.record_id;
      end
      if (root_a_load) begin
         root_a_ff <= sq_root;
      end
      if (score_load) begin
         score_ff <= score_val;
      end
      if (k_load) begin
         k_ff    <= k_calc;
         rank_ff <= '0;
      end else if (rsp_load) begin
         rank_ff <= rank_ff + 1'b1;
      end
      if (rsp_load) begin
         rsp_rank_ff   <= rsp_rank_val;
         rsp_hit_id_ff <= rsp_id_val;
         rsp_score_ff  <= rsp_score_val;
         rsp_status_ff <= rsp_status_val;
         rsp_last_ff   <= rsp_load_last;
      end
   end

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.rank   = rsp_rank_ff;
   assign rsp_if.hit_id = rsp_hit_id_ff;
   assign rsp_if.score  = rsp_score_ff;
   assign rsp_if.status = rsp_status_ff;
   assign rsp_if.last   = rsp_last_ff;

   // Hit list: entry 0 is the best, new scores ripple in from the tail side.
   for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
      entry_type left_e, right_e;
      logic      left_t, right_t;
      if (g == 0) begin : g_head
         assign left_e = '0;
         assign left_t = 1'b0;
      end else begin : g_mid_l
         assign left_e = entries[g-1];
         assign left_t = takes[g-1];
      end
      if (g == MAX_KEEP - 1) begin : g_tail
         assign right_e = '0;
         assign right_t = 1'b1;
      end else begin : g_mid_r
         assign right_e = entries[g+1];
         assign right_t = takes[g+1];
      end
      tkvs_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_entry  (left_e),
         .left_take   (left_t),
         .right_entry (right_e),
         .right_take  (right_t),
         .entry       (entries[g]),
         .take        (takes[g])
      );
      assign valid_vec[g] = entries[g].valid;
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      state_ff != S_EMIT |-> $countones(valid_vec) == best_fill_ff)
      else $error("Hit list occupancy disagrees with the fill count.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_HIT |-> rsp_last_ff)
      else $error("An error or empty response is not marked last.");

   assert property (@(posedge clock) disable iff (reset)
      elem_ff <= QCNT_W'(MAX_DIM))
      else $error("Element index ran past the longest vector.");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> k_ff != '0 && k_ff <= best_fill_ff)
      else $error("Emit count is out of range for the hit list.");
`endif

endmodule

[verif/tb_top_k_vector_similarity_search.sv]
`timescale 1ns / 1ps
// Testbench of top_k_vector_similarity_search: directed and random searches with their
// expected ranked hits, predicted here and checked at the response channel.
// Depends on tkvs_pkg, tkvs_intf and the block itself.
module tb_top_k_vector_similarity_search;
   import tkvs_pkg::*;

   localparam int LIMIT = 1000000;
   localparam int SETTLE = 200;

   typedef struct {
      kind_type          kind;
      logic [ID_W-1:0]   id;
      logic signed [VALUE_W-1:0] value;
   } request_type;

   typedef struct {
      logic [RANK_W-1:0]          rank;
      logic [ID_W-1:0]            hit_id;
      logic signed [SCORE_W-1:0]  score;
      status_type                 status;
      logic                       last;
   } hit_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;

   tkvs_req_if req_if ();
   tkvs_rsp_if rsp_if ();

   top_k_vector_similarity_search dut (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   request_type pending_q[$];
   hit_type     hits_q[$];
   int src_idle_pct = 0;
   int sink_stall_pct = 0;
   bit req_taken = 0;
   bit failed = 0;
   int cycles = 0;
   int random_items = 0;

   // Predictor state.
   int unsigned cfg_length = 256;
   int unsigned cfg_keep = 16;
   logic cfg_metric = METRIC_COSINE;
   logic signed [VALUE_W-1:0] query_mem [MAX_DIM];
   int unsigned query_count;
   int unsigned elem_pos;
   longint signed dot_sum;
   longint unsigned rec_norm, diff_sq, query_norm;
   logic signed [SCORE_W-1:0] rank_scores [MAX_KEEP];
   logic [ID_W-1:0] rank_ids [MAX_KEEP];
   int unsigned rank_fill;
   bit any_record;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned lo, hi, mid;
      lo = 0;
      hi = 64'd4294967296;
      while (hi - lo > 1) begin
         mid = (lo + hi) >> 1;
         if (mid * mid <= x) lo = mid;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic logic signed [SCORE_W-1:0] cosine_of_record();
      longint unsigned den, mag, quo;
      if (query_norm == 0 || rec_norm == 0) return 0;
      den = int_sqrt(query_norm) * int_sqrt(rec_norm);
      if (den == 0) return 0;
      mag = (dot_sum < 0) ? longint'(-dot_sum) : longint'(dot_sum);
      quo = (mag << COS_SHIFT) / den;
      if (quo > COS_ONE) quo = COS_ONE;
      return (dot_sum < 0) ? -SCORE_W'(quo) : SCORE_W'(quo);
   endfunction

   function automatic bit ranks_above(input logic signed [SCORE_W-1:0] a,
                                      input logic signed [SCORE_W-1:0] b);
      return (cfg_metric == METRIC_COSINE) ? (a > b) : (a < b);
   endfunction

   function automatic void clear_record();
      elem_pos = 0;
      dot_sum = 0;
      rec_norm = 0;
      diff_sq = 0;
   endfunction

   function automatic void push_hit(input int unsigned rank, input logic [ID_W-1:0] id,
                                    input logic signed [SCORE_W-1:0] score,
                                    input status_type status, input bit last);
      hit_type h;
      h.rank = RANK_W'(rank);
      h.hit_id = id;
      h.score = score;
      h.status = status;
      h.last = last;
      hits_q.insert(hits_q.size(), h);
   endfunction

   function automatic void predict_hits(input request_type r);
      longint signed q, v, d;
      logic signed [SCORE_W-1:0] s;
      int unsigned eff_len, pos, top, k;
      eff_len = (cfg_length < 1) ? 1 : (cfg_length > MAX_DIM) ? MAX_DIM : cfg_length;
      v = r.value;
      case (r.kind)
         KIND_QUERY: begin
            if (query_count < MAX_DIM) begin
               query_mem[query_count] = r.value;
               query_norm += longint'(v * v);
            end
            if (query_count < MAX_DIM + 1) query_count++;
         end
         KIND_RECORD: begin
            q = (elem_pos < query_count && elem_pos < MAX_DIM) ? query_mem[elem_pos] : 0;
            d = q - v;
            dot_sum += q * v;
            rec_norm += longint'(v * v);
            diff_sq += longint'(d * d);
            elem_pos++;
            if (elem_pos >= eff_len) begin
               s = (cfg_metric == METRIC_COSINE) ? cosine_of_record()
                                                 : SCORE_W'(int_sqrt(diff_sq));
               pos = rank_fill;
               while (pos > 0 && ranks_above(s, rank_scores[pos-1])) pos--;
               if (pos < MAX_KEEP) begin
                  top = (rank_fill < MAX_KEEP) ? rank_fill : MAX_KEEP - 1;
                  for (int i = top; i > pos; i--) begin
                     rank_scores[i] = rank_scores[i-1];
                     rank_ids[i] = rank_ids[i-1];
                  end
                  rank_scores[pos] = s;
                  rank_ids[pos] = r.id;
                  if (rank_fill < MAX_KEEP) rank_fill++;
               end
               any_record = 1;
               clear_record();
            end
         end
         KIND_END: begin
            k = (cfg_keep < MAX_KEEP) ? cfg_keep : MAX_KEEP;
            if (query_count != eff_len) begin
               push_hit(0, 0, 0, STATUS_MISMATCH, 1);
            end else if (!any_record || k == 0) begin
               push_hit(0, 0, 0, STATUS_EMPTY, 1);
            end else begin
               if (k > rank_fill) k = rank_fill;
               for (int i = 0; i < k; i++)
                  push_hit(i, rank_ids[i], rank_scores[i], STATUS_HIT, i + 1 == k);
            end
            query_count = 0;
            query_norm = 0;
            rank_fill = 0;
            any_record = 0;
            clear_record();
         end
         default: ;
      endcase
   endfunction

   // Request driver and response ready, changed at the falling edge.
   always @(negedge clock) begin
      request_type r;
      if (!reset && (!req_if.valid || req_taken)) begin
         if (pending_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
            r = pending_q.pop_front();
            req_if.valid <= 1'b1;
            req_if.kind <= r.kind;
            req_if.record_id <= r.id;
            req_if.value <= r.value;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
      rsp_if.ready <= !reset && ($urandom_range(99) >= sink_stall_pct);
   end

   // Monitor: predicts on each accepted request and checks each accepted hit.
   always @(posedge clock) begin
      request_type r;
      hit_type h;
      cycles++;
      if (cycles > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
      req_taken = req_if.valid && req_if.ready;
      if (!reset && req_taken) begin
         r.kind = kind_type'(req_if.kind);
         r.id = req_if.record_id;
         r.value = req_if.value;
         predict_hits(r);
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (hits_q.size() == 0) begin
            $error("unexpected hit: rank %0d id %0h", rsp_if.rank, rsp_if.hit_id);
            failed = 1;
         end else begin
            h = hits_q.pop_front();
            if (rsp_if.rank !== h.rank) begin
               $error("rank: expected %0d actual %0d", h.rank, rsp_if.rank);
               failed = 1;
            end
            if (rsp_if.hit_id !== h.hit_id) begin
               $error("hit_id: expected %0h actual %0h", h.hit_id, rsp_if.hit_id);
               failed = 1;
            end
            if (rsp_if.score !== h.score) begin
               $error("score: expected %0d actual %0d", h.score, rsp_if.score);
               failed = 1;
            end
            if (rsp_if.status !== h.status) begin
               $error("status: expected %0d actual %0d", h.status, rsp_if.status);
               failed = 1;
            end
            if (rsp_if.last !== h.last) begin
               $error("last: expected %0d actual %0d", h.last, rsp_if.last);
               failed = 1;
            end
         end
      end
   end

   task automatic add_request(input kind_type kind, input logic [ID_W-1:0] id,
                              input logic signed [VALUE_W-1:0] value);
      request_type r;
      r.kind = kind;
      r.id = id;
      r.value = value;
      pending_q.insert(pending_q.size(), r);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 0;
         3: return VALUE_W'($urandom_range(8191) - 4096);
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   task automatic wait_quiet();
      while (pending_q.size() > 0 || req_if.valid || hits_q.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type index, input int unsigned data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_W'(4 * index);
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         REG_VECTOR_LENGTH: cfg_length = data & 9'h1FF;
         REG_KEEP_COUNT: cfg_keep = data & 5'h1F;
         default: cfg_metric = data[0];
      endcase
   endtask

   task automatic configure(input int unsigned len, input int unsigned keep,
                            input logic metric);
      wait_quiet();
      csr_write(REG_VECTOR_LENGTH, len);
      csr_write(REG_KEEP_COUNT, keep);
      csr_write(REG_METRIC_MODE, metric);
   endtask

   task automatic add_search(input int nquery, input int nrec, input int partial,
                             input bit noisy);
      for (int i = 0; i < nquery; i++) add_request(KIND_QUERY, $urandom, pick_value());
      for (int j = 0; j < nrec; j++) begin
         for (int i = 0; i < cfg_length; i++) begin
            if (noisy && $urandom_range(15) == 0)
               add_request(KIND_UNUSED, $urandom, pick_value());
            add_request(KIND_RECORD, $urandom, pick_value());
         end
      end
      for (int i = 0; i < partial; i++) add_request(KIND_RECORD, $urandom, pick_value());
      add_request(KIND_END, $urandom, pick_value());
   endtask

   initial begin
      int len, nq, nrec, mode;
      reset = 1;
      req_if.valid = 0;
      req_if.kind = KIND_QUERY;
      req_if.record_id = 0;
      req_if.value = 0;
      rsp_if.ready = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = 0;
      csr_pwdata = 0;
      query_count = 0;
      query_norm = 0;
      rank_fill = 0;
      any_record = 0;
      clear_record();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Field extremes, tie on equal records, and an ignored kind.
      configure(2, 16, METRIC_COSINE);
      add_request(KIND_QUERY, 0, -16'sd32768);
      add_request(KIND_QUERY, 0, 16'sd32767);
      add_request(KIND_UNUSED, 32'hFFFF_FFFF, 16'sd1);
      add_request(KIND_RECORD, 0, -16'sd32768);
      add_request(KIND_RECORD, 32'hFFFF_FFFF, 16'sd32767);
      add_request(KIND_RECORD, 0, -16'sd32768);
      add_request(KIND_RECORD, 32'h5555_AAAA, 16'sd32767);
      add_request(KIND_RECORD, 0, 16'sd32767);
      add_request(KIND_RECORD, 32'hAAAA_5555, -16'sd32768);
      add_request(KIND_END, 0, 0);
      // Zero query norm, then an empty search and a record left incomplete.
      add_request(KIND_QUERY, 0, 0);
      add_request(KIND_QUERY, 0, 0);
      add_request(KIND_RECORD, 0, 16'sd5);
      add_request(KIND_RECORD, 7, 16'sd9);
      add_request(KIND_END, 0, 0);
      add_search(2, 0, 1, 0);
      // Missing query elements give a mismatch.
      add_search(1, 1, 0, 0);
      // Random records under distance, with keep count zero and then one.
      configure(2, 0, METRIC_EUCLID);
      add_search(2, 2, 0, 0);
      configure(2, 1, METRIC_EUCLID);
      add_search(2, 3, 0, 0);
      // Shortened length and a metric change in the middle of a search.
      configure(4, 16, METRIC_COSINE);
      for (int i = 0; i < 4; i++) add_request(KIND_QUERY, 0, pick_value());
      for (int i = 0; i < 6; i++) add_request(KIND_RECORD, i, pick_value());
      wait_quiet();
      csr_write(REG_VECTOR_LENGTH, 2);
      add_request(KIND_RECORD, 99, pick_value());
      wait_quiet();
      csr_write(REG_METRIC_MODE, METRIC_EUCLID);
      csr_write(REG_VECTOR_LENGTH, 4);
      for (int i = 0; i < 8; i++) add_request(KIND_RECORD, 100 + i / 4, pick_value());
      add_request(KIND_END, 0, 0);
      // Query elements past the store size, and a hit list that overflows.
      configure(256, 16, METRIC_COSINE);
      add_search(257, 0, 0, 0);
      configure(1, 16, METRIC_EUCLID);
      add_search(1, 20, 0, 0);

      mode = 0;
      while (random_items < 60 || mode < 4) begin
         case (mode % 4)
            0: begin src_idle_pct = 0; sink_stall_pct = 0; end
            1: begin src_idle_pct = 45; sink_stall_pct = 0; end
            2: begin src_idle_pct = 0; sink_stall_pct = 45; end
            default: begin src_idle_pct = 13; sink_stall_pct = 13; end
         endcase
         mode++;
         len = ($urandom_range(15) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
         configure(len, $urandom_range(0, 16), $urandom_range(1));
         nq = ($urandom_range(7) == 0) ? len + $urandom_range(2) - 1 : len;
         nrec = $urandom_range(0, 20);
         if (nrec * len > 20) nrec = (len > 20) ? 1 : 20 / len;
         add_search(nq, nrec, ($urandom_range(5) == 0) ? $urandom_range(len - 1) : 0,
                    $urandom_range(1));
         random_items += nq + nrec * len + 1;
      end

      while (pending_q.size() > 0 || req_if.valid || hits_q.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (!failed && hits_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
